>>> hdl/pdpc_pkg.sv
// shared widths, constants, multiplier operand codes and the controller/datapath
// command and status structs for the pd position/current controller
// no dependencies
package pdpc_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned GAIN_W     = 31;
    localparam int unsigned LIMIT_W    = 31;
    localparam int unsigned POLES_W    = 8;
    localparam int unsigned WEIGHT_W   = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 31;

    // shared multiplier and accumulator
    localparam int unsigned MUL_W  = 34;
    localparam int unsigned PROD_W = 2 * MUL_W;
    localparam int unsigned ACC_W  = 50;

    // pole-pair divider
    localparam int unsigned DVD_W     = 31;
    localparam int unsigned DVS_W     = 8;
    localparam int unsigned DIV_CNT_W = $clog2(DVD_W + 1);

    // pi/180 and pi/30 in Q0.32
    localparam logic [MUL_W-1:0] DEG_TO_RAD_Q32  = MUL_W'(74961321);
    localparam logic [MUL_W-1:0] RPM_TO_RADS_Q32 = MUL_W'(449767923);

    localparam logic [POLES_W-1:0]  POLES_RST  = POLES_W'(14);
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(3276800);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(6554);

    typedef enum logic [2:0] {
        MUL_ERPM_NEW,
        MUL_FILT_OLD,
        MUL_ANGLE,
        MUL_RATE,
        MUL_KP,
        MUL_KD
    } t_mul_op;

    typedef struct packed {
        logic    load_in;
        logic    mul_load;
        t_mul_op mul_op;
        logic    acc_filt_init;
        logic    filt_update;
        logic    ang_update;
        logic    mag_update;
        logic    div_start;
        logic    acc_kp_init;
        logic    acc_add_ff;
        logic    rate_update;
        logic    term_update;
        logic    acc_add_term;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_stat;

endpackage

>>> hdl/pd_position_current_controller.sv
// top level of the pd position/current controller with feed-forward current
// depends on pdpc_pkg, pdpc_controller, pdpc_datapath (and pdpc_divider below it)

// One control-tick transaction in, one result out. Each input transaction carries the
// measured angle (degrees), measured erpm, target angle and rate, the two gains and the
// feed-forward current, all Q16.16. The block low-pass filters the erpm (filter state
// survives between transactions and clears on reset), converts angle to rad and speed
// to rad/s through the pole-pair count, forms kp*angle error + kd*rate error + ff and
// clamps it to +/- current_limit, flagging the clamp. Transactions are handled one at a
// time, built around a single shared 34x34 multiplier (six products, each loaded,
// multiplied and then used) and a 31-step restoring divider for the pole-pair scaling,
// which overlaps the stiffness product. A finished result sits in the output register
// while the next transaction is accepted and worked on. Config writes (motor_poles,
// current_limit, filter_weight) take effect at once and belong in idle time.
module pd_position_current_controller
    import pdpc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // config write port
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_wdata,
    // input transaction
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [DATA_W-1:0]  i_measured_angle,
    input  logic signed [DATA_W-1:0]  i_measured_erpm,
    input  logic signed [DATA_W-1:0]  i_target_angle,
    input  logic signed [DATA_W-1:0]  i_target_rate,
    input  logic [GAIN_W-1:0]         i_stiffness_gain,
    input  logic [GAIN_W-1:0]         i_damping_gain,
    input  logic signed [DATA_W-1:0]  i_feedforward_current,
    // result transaction
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [DATA_W-1:0]  o_current_command,
    output logic signed [DATA_W-1:0]  o_angle_radians,
    output logic signed [DATA_W-1:0]  o_rate_radians,
    output logic                      o_clamped
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: one state per multiplier phase, waits on the divider and the result slot
    pdpc_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // arithmetic, config registers, filter state and the result register
    pdpc_datapath u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_measured_angle      (i_measured_angle),
        .i_measured_erpm       (i_measured_erpm),
        .i_target_angle        (i_target_angle),
        .i_target_rate         (i_target_rate),
        .i_stiffness_gain      (i_stiffness_gain),
        .i_damping_gain        (i_damping_gain),
        .i_feedforward_current (i_feedforward_current),
        .i_cmd                 (w_cmd),
        .o_stat                (w_stat),
        .o_current_command     (o_current_command),
        .o_angle_radians       (o_angle_radians),
        .o_rate_radians        (o_rate_radians),
        .o_clamped             (o_clamped)
    );

`ifndef ASSERT_OFF
    // an accepted transaction takes the block out of idle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready right after an accepted transaction");

    // a result is only written into a free (or draining) output slot
    a_load_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten while still pending");

    // a fresh divide must not look finished on the next cycle
    a_div_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> !w_stat.div_done)
        else $error("divider done flag not cleared by start");

    // the divider only starts inside a transaction
    a_div_busy_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !o_in_ready)
        else $error("divider started while idle");
`endif

endmodule

>>> hdl/pdpc_divider.sv
// restoring divider, one quotient bit per cycle, for the pole-pair scaling
// depends on pdpc_pkg
module pdpc_divider
    import pdpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [DVD_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_divisor;

    logic [DVS_W:0] w_shift;
    logic [DVS_W:0] w_diff;
    logic           w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[DVD_W-1]};
        w_ge    = (w_shift >= {1'b0, r_divisor});
        w_diff  = w_shift - {1'b0, r_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> hdl/pdpc_datapath.sv
// datapath: config registers, speed filter state, shared 34x34 multiplier,
// accumulator, clamp and result registers
// depends on pdpc_pkg and pdpc_divider
module pdpc_datapath
    import pdpc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic signed [DATA_W-1:0]  i_measured_angle,
    input  logic signed [DATA_W-1:0]  i_measured_erpm,
    input  logic signed [DATA_W-1:0]  i_target_angle,
    input  logic signed [DATA_W-1:0]  i_target_rate,
    input  logic [GAIN_W-1:0]         i_stiffness_gain,
    input  logic [GAIN_W-1:0]         i_damping_gain,
    input  logic signed [DATA_W-1:0]  i_feedforward_current,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    output logic signed [DATA_W-1:0]  o_current_command,
    output logic signed [DATA_W-1:0]  o_angle_radians,
    output logic signed [DATA_W-1:0]  o_rate_radians,
    output logic                      o_clamped
);

    localparam logic [CFG_IDX_W-1:0] CFG_POLES  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = CFG_IDX_W'(2);

    localparam logic signed [PROD_W-1:0] RND_Q16 = PROD_W'(64'd1 << 15);
    localparam logic signed [PROD_W-1:0] RND_Q32 = PROD_W'(64'd1 << 31);
    localparam int unsigned MAG_W   = DVD_W - 1;
    localparam int unsigned PAIRS_W = POLES_W - 1;

    logic [POLES_W-1:0]  r_motor_poles;
    logic [LIMIT_W-1:0]  r_current_limit;
    logic [WEIGHT_W-1:0] r_filter_weight;

    logic signed [DATA_W-1:0] r_angle;
    logic signed [DATA_W-1:0] r_erpm;
    logic signed [DATA_W-1:0] r_tgt_angle;
    logic signed [DATA_W-1:0] r_tgt_rate;
    logic [GAIN_W-1:0]        r_kp;
    logic [GAIN_W-1:0]        r_kd;
    logic signed [DATA_W-1:0] r_ff;

    logic signed [DATA_W-1:0] r_filt;
    logic signed [MUL_W-1:0]  r_mul_a;
    logic signed [MUL_W-1:0]  r_mul_b;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_term;
    logic signed [DATA_W-1:0] r_ang_rad;
    logic signed [DATA_W-1:0] r_rate;
    logic [MAG_W-1:0]         r_mag_hi;
    logic                     r_neg;

    logic signed [DATA_W-1:0] r_out_cmd;
    logic signed [DATA_W-1:0] r_out_ang;
    logic signed [DATA_W-1:0] r_out_rate;
    logic                     r_out_clamped;

    logic [PAIRS_W-1:0]       w_pairs;
    logic [WEIGHT_W:0]        w_weight_cmp;
    logic signed [MUL_W-1:0]  w_op_a;
    logic signed [MUL_W-1:0]  w_op_b;
    logic signed [PROD_W-1:0] w_rnd16;
    logic signed [PROD_W-1:0] w_rnd32;
    logic signed [PROD_W-1:0] w_mag;
    logic signed [ACC_W-1:0]  w_filt_sum;
    logic [DVD_W-1:0]         w_dividend;
    logic [DVS_W-1:0]         w_divisor;
    logic                     w_div_done;
    logic [DVD_W-1:0]         w_quot;
    logic signed [DATA_W-1:0] w_quot_ext;
    logic signed [ACC_W-1:0]  w_lim;
    logic signed [ACC_W-1:0]  w_lo_sum;
    logic signed [DATA_W-1:0] w_neg_lim;
    logic                     w_at_low;
    logic                     w_at_high;
    logic signed [DATA_W-1:0] w_clamp_val;
    logic                     w_clamp_hit;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_poles   <= POLES_RST;
            r_current_limit <= LIMIT_RST;
            r_filter_weight <= WEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_POLES:  r_motor_poles   <= i_cfg_wdata[POLES_W-1:0];
                CFG_LIMIT:  r_current_limit <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_WEIGHT: r_filter_weight <= i_cfg_wdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // fewer than two poles counts as one pole pair
    assign w_pairs      = (r_motor_poles[POLES_W-1:1] == '0) ? PAIRS_W'(1)
                                                             : r_motor_poles[POLES_W-1:1];
    assign w_divisor    = {w_pairs, 1'b0};
    assign w_weight_cmp = {1'b1, {WEIGHT_W{1'b0}}} - {1'b0, r_filter_weight};

    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        unique case (i_cmd.mul_op)
            MUL_ERPM_NEW: begin
                w_op_a = {{(MUL_W-DATA_W){r_erpm[DATA_W-1]}}, r_erpm};
                w_op_b = {{(MUL_W-WEIGHT_W){1'b0}}, r_filter_weight};
            end
            MUL_FILT_OLD: begin
                w_op_a = {{(MUL_W-DATA_W){r_filt[DATA_W-1]}}, r_filt};
                w_op_b = {{(MUL_W-WEIGHT_W-1){1'b0}}, w_weight_cmp};
            end
            MUL_ANGLE: begin
                w_op_a = {{(MUL_W-DATA_W){r_angle[DATA_W-1]}}, r_angle};
                w_op_b = DEG_TO_RAD_Q32;
            end
            MUL_RATE: begin
                w_op_a = {{(MUL_W-DATA_W){r_filt[DATA_W-1]}}, r_filt};
                w_op_b = RPM_TO_RADS_Q32;
            end
            MUL_KP: begin
                w_op_a = {{(MUL_W-GAIN_W){1'b0}}, r_kp};
                w_op_b = {{(MUL_W-DATA_W){r_tgt_angle[DATA_W-1]}}, r_tgt_angle}
                       - {{(MUL_W-DATA_W){r_ang_rad[DATA_W-1]}}, r_ang_rad};
            end
            MUL_KD: begin
                w_op_a = {{(MUL_W-GAIN_W){1'b0}}, r_kd};
                w_op_b = {{(MUL_W-DATA_W){r_tgt_rate[DATA_W-1]}}, r_tgt_rate}
                       - {{(MUL_W-DATA_W){r_rate[DATA_W-1]}}, r_rate};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_rnd16    = r_prod + RND_Q16;
    assign w_rnd32    = r_prod + RND_Q32;
    assign w_mag      = r_prod[PROD_W-1] ? -r_prod : r_prod;
    assign w_filt_sum = r_acc + $signed(r_prod[ACC_W-1:0]);
    // round half away from zero: floor((|p| >> 31 + pairs) / (2 * pairs))
    assign w_dividend = {1'b0, r_mag_hi} + DVD_W'(w_pairs);
    assign w_quot_ext = {{(DATA_W-DVD_W){1'b0}}, w_quot};

    pdpc_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign o_stat.div_done = w_div_done;

    // clamp, equality counts as hitting the limit
    assign w_lim     = $signed({{(ACC_W-LIMIT_W){1'b0}}, r_current_limit});
    assign w_lo_sum  = r_acc + w_lim;
    assign w_at_low  = w_lo_sum[ACC_W-1] || (w_lo_sum == '0);
    assign w_at_high = (r_acc >= w_lim);
    assign w_neg_lim = -$signed({{(DATA_W-LIMIT_W){1'b0}}, r_current_limit});

    always_comb begin
        priority if (w_at_low) begin
            w_clamp_val = w_neg_lim;
            w_clamp_hit = 1'b1;
        end else if (w_at_high) begin
            w_clamp_val = {{(DATA_W-LIMIT_W){1'b0}}, r_current_limit};
            w_clamp_hit = 1'b1;
        end else begin
            w_clamp_val = r_acc[DATA_W-1:0];
            w_clamp_hit = 1'b0;
        end
    end

    // speed filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= '0;
        end else if (i_cmd.filt_update) begin
            r_filt <= w_filt_sum[DATA_W+15:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_angle     <= i_measured_angle;
            r_erpm      <= i_measured_erpm;
            r_tgt_angle <= i_target_angle;
            r_tgt_rate  <= i_target_rate;
            r_kp        <= i_stiffness_gain;
            r_kd        <= i_damping_gain;
            r_ff        <= i_feedforward_current;
        end
        if (i_cmd.mul_load) begin
            r_mul_a <= w_op_a;
            r_mul_b <= w_op_b;
        end
        r_prod <= r_mul_a * r_mul_b;
        priority if (i_cmd.acc_filt_init) begin
            r_acc <= w_rnd16[ACC_W-1:0];
        end else if (i_cmd.acc_kp_init) begin
            r_acc <= w_rnd16[ACC_W+15:16];
        end else if (i_cmd.acc_add_ff) begin
            r_acc <= r_acc + $signed({{(ACC_W-DATA_W){r_ff[DATA_W-1]}}, r_ff});
        end else if (i_cmd.acc_add_term) begin
            r_acc <= r_acc + r_term;
        end
        if (i_cmd.term_update) begin
            r_term <= w_rnd16[ACC_W+15:16];
        end
        if (i_cmd.ang_update) begin
            r_ang_rad <= w_rnd32[DATA_W+31:32];
        end
        if (i_cmd.mag_update) begin
            r_mag_hi <= w_mag[MAG_W+30:31];
            r_neg    <= r_prod[PROD_W-1];
        end
        if (i_cmd.rate_update) begin
            r_rate <= r_neg ? -w_quot_ext : w_quot_ext;
        end
        if (i_cmd.load_out) begin
            r_out_cmd     <= w_clamp_val;
            r_out_ang     <= r_ang_rad;
            r_out_rate    <= r_rate;
            r_out_clamped <= w_clamp_hit;
        end
    end

    assign o_current_command = r_out_cmd;
    assign o_angle_radians   = r_out_ang;
    assign o_rate_radians    = r_out_rate;
    assign o_clamped         = r_out_clamped;

endmodule

>>> hdl/pdpc_controller.sv
// sequencing state machine: steps the shared multiplier, starts the divider,
// and owns the input ready and result valid handshakes
// depends on pdpc_pkg
module pdpc_controller
    import pdpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_F0_LD    = 5'd1;
    localparam logic [4:0] S_F0_MUL   = 5'd2;
    localparam logic [4:0] S_F0_USE   = 5'd3;
    localparam logic [4:0] S_F1_LD    = 5'd4;
    localparam logic [4:0] S_F1_MUL   = 5'd5;
    localparam logic [4:0] S_F1_USE   = 5'd6;
    localparam logic [4:0] S_AN_LD    = 5'd7;
    localparam logic [4:0] S_AN_MUL   = 5'd8;
    localparam logic [4:0] S_AN_USE   = 5'd9;
    localparam logic [4:0] S_RT_LD    = 5'd10;
    localparam logic [4:0] S_RT_MUL   = 5'd11;
    localparam logic [4:0] S_RT_USE   = 5'd12;
    localparam logic [4:0] S_DIV_GO   = 5'd13;
    localparam logic [4:0] S_KP_LD    = 5'd14;
    localparam logic [4:0] S_KP_MUL   = 5'd15;
    localparam logic [4:0] S_KP_USE   = 5'd16;
    localparam logic [4:0] S_FF_ADD   = 5'd17;
    localparam logic [4:0] S_DIV_WAIT = 5'd18;
    localparam logic [4:0] S_RATE     = 5'd19;
    localparam logic [4:0] S_KD_LD    = 5'd20;
    localparam logic [4:0] S_KD_MUL   = 5'd21;
    localparam logic [4:0] S_KD_USE   = 5'd22;
    localparam logic [4:0] S_SUM      = 5'd23;
    localparam logic [4:0] S_OUT      = 5'd24;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_op = MUL_ERPM_NEW;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_F0_LD;
                end
            end
            S_F0_LD: begin
                o_cmd.mul_load = 1'b1;
                o_cmd.mul_op   = MUL_ERPM_NEW;
                n_state = S_F0_MUL;
            end
            S_F0_MUL: n_state = S_F0_USE;
            S_F0_USE: begin
                o_cmd.acc_filt_init = 1'b1;
                n_state = S_F1_LD;
            end
            S_F1_LD: begin
                o_cmd.mul_load = 1'b1;
                o_cmd.mul_op   = MUL_FILT_OLD;
                n_state = S_F1_MUL;
            end
            S_F1_MUL: n_state = S_F1_USE;
            S_F1_USE: begin
                o_cmd.filt_update = 1'b1;
                n_state = S_AN_LD;
            end
            S_AN_LD: begin
                o_cmd.mul_load = 1'b1;
                o_cmd.mul_op   = MUL_ANGLE;
                n_state = S_AN_MUL;
            end
            S_AN_MUL: n_state = S_AN_USE;
            S_AN_USE: begin
                o_cmd.ang_update = 1'b1;
                n_state = S_RT_LD;
            end
            S_RT_LD: begin
                o_cmd.mul_load = 1'b1;
                o_cmd.mul_op   = MUL_RATE;
                n_state = S_RT_MUL;
            end
            S_RT_MUL: n_state = S_RT_USE;
            S_RT_USE: begin
                o_cmd.mag_update = 1'b1;
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_KP_LD;
            end
            S_KP_LD: begin
                o_cmd.mul_load = 1'b1;
                o_cmd.mul_op   = MUL_KP;
                n_state = S_KP_MUL;
            end
            S_KP_MUL: n_state = S_KP_USE;
            S_KP_USE: begin
                o_cmd.acc_kp_init = 1'b1;
                n_state = S_FF_ADD;
            end
            S_FF_ADD: begin
                o_cmd.acc_add_ff = 1'b1;
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_RATE;
                end
            end
            S_RATE: begin
                o_cmd.rate_update = 1'b1;
                n_state = S_KD_LD;
            end
            S_KD_LD: begin
                o_cmd.mul_load = 1'b1;
                o_cmd.mul_op   = MUL_KD;
                n_state = S_KD_MUL;
            end
            S_KD_MUL: n_state = S_KD_USE;
            S_KD_USE: begin
                o_cmd.term_update = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.acc_add_term = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> test/pdpc_tick_pkg.sv
// control-tick and result transaction types plus config register indexes
// shared by the pd position/current controller testbench files; depends on pdpc_pkg
`timescale 1ns / 1ps

package pdpc_tick_pkg;
    import pdpc_pkg::*;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOTOR_POLES   = 0,
        REG_CURRENT_LIMIT = 1,
        REG_FILTER_WEIGHT = 2
    } t_cfg_reg;

    typedef struct packed {
        logic signed [DATA_W-1:0] measured_angle;
        logic signed [DATA_W-1:0] measured_erpm;
        logic signed [DATA_W-1:0] target_angle;
        logic signed [DATA_W-1:0] target_rate;
        logic [GAIN_W-1:0]        stiffness_gain;
        logic [GAIN_W-1:0]        damping_gain;
        logic signed [DATA_W-1:0] feedforward_current;
    } t_tick;

    typedef struct packed {
        logic signed [DATA_W-1:0] current_command;
        logic signed [DATA_W-1:0] angle_radians;
        logic signed [DATA_W-1:0] rate_radians;
        logic                     clamped;
    } t_command;

endpackage

>>> test/pdpc_command_checker.sv
// watches the config port and both transaction channels of the pd controller,
// predicts every current command and compares it; depends on pdpc_pkg, pdpc_tick_pkg
`timescale 1ns / 1ps

module pdpc_command_checker
    import pdpc_pkg::*;
    import pdpc_tick_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_tick                 i_tick,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_command              i_result,
    output int                    o_mismatch_count,
    output int                    o_pending
);

    // pi/180 and pi/30 in Q0.32
    localparam longint PI_OVER_180_Q32 = 74961321;
    localparam longint PI_OVER_30_Q32  = 449767923;

    logic [POLES_W-1:0]  motor_poles;
    logic [LIMIT_W-1:0]  current_limit;
    logic [WEIGHT_W-1:0] filter_weight;
    longint              filtered_erpm;

    t_command expected_commands[$];
    t_command want;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_mismatch_count++;
    endtask

    // round to nearest, ties up, by a floor shift
    function automatic longint round_shift(input longint x, input int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // advances the speed filter and works out the result of one tick
    function automatic t_command predict_command(input t_tick t);
        longint angle, erpm, tgt_angle, tgt_rate, kp, kd, ff;
        longint w, limit, pairs, ang_rad, rate, prod, sum;
        longint unsigned mag, den, quot;
        t_command c;
        angle     = longint'(signed'(t.measured_angle));
        erpm      = longint'(signed'(t.measured_erpm));
        tgt_angle = longint'(signed'(t.target_angle));
        tgt_rate  = longint'(signed'(t.target_rate));
        ff        = longint'(signed'(t.feedforward_current));
        kp        = {33'b0, t.stiffness_gain};
        kd        = {33'b0, t.damping_gain};
        w         = {48'b0, filter_weight};
        limit     = {33'b0, current_limit};

        filtered_erpm = round_shift(erpm * w + filtered_erpm * (65536 - w), 16);
        ang_rad = round_shift(angle * PI_OVER_180_Q32, 32);

        // fewer than two poles behaves as one pole pair
        pairs = {56'b0, motor_poles} >> 1;
        if (pairs == 0) begin
            pairs = 1;
        end
        // rpm to rad/s divided by pole pairs, rounded half away from zero
        prod = filtered_erpm * PI_OVER_30_Q32;
        mag  = (prod < 0) ? -prod : prod;
        den  = longint'(pairs) << 32;
        quot = (mag + den / 2) / den;
        rate = (prod < 0) ? -$signed(quot) : $signed(quot);

        sum = round_shift(kp * (tgt_angle - ang_rad), 16)
            + round_shift(kd * (tgt_rate - rate), 16)
            + ff;

        // limit reached includes equality, so a zero limit always clamps
        c.clamped = 1'b0;
        if (sum <= -limit) begin
            sum = -limit;
            c.clamped = 1'b1;
        end else if (sum >= limit) begin
            sum = limit;
            c.clamped = 1'b1;
        end
        c.current_command = sum[DATA_W-1:0];
        c.angle_radians   = ang_rad[DATA_W-1:0];
        c.rate_radians    = rate[DATA_W-1:0];
        return c;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            motor_poles   = 8'd14;
            current_limit = 31'd3276800;
            filter_weight = 16'd6554;
            filtered_erpm = 0;
            expected_commands.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_MOTOR_POLES:   motor_poles   = i_cfg_wdata[POLES_W-1:0];
                    REG_CURRENT_LIMIT: current_limit = i_cfg_wdata[LIMIT_W-1:0];
                    REG_FILTER_WEIGHT: filter_weight = i_cfg_wdata[WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            // results first so a result is never matched to the tick taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_commands.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending, command %0d",
                                              i_result.current_command));
                end else begin
                    want = expected_commands.pop_front();
                    if (i_result.current_command !== want.current_command)
                        report_mismatch($sformatf("current_command got %0d want %0d",
                                        i_result.current_command, want.current_command));
                    if (i_result.angle_radians !== want.angle_radians)
                        report_mismatch($sformatf("angle_radians got %0d want %0d",
                                        i_result.angle_radians, want.angle_radians));
                    if (i_result.rate_radians !== want.rate_radians)
                        report_mismatch($sformatf("rate_radians got %0d want %0d",
                                        i_result.rate_radians, want.rate_radians));
                    if (i_result.clamped !== want.clamped)
                        report_mismatch($sformatf("clamped got %0b want %0b",
                                        i_result.clamped, want.clamped));
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_commands.push_back(predict_command(i_tick));
            end
        end
        o_pending = expected_commands.size();
    end

endmodule

>>> test/pd_position_current_controller_test.sv
// top of the pd position/current controller testbench: clock, reset, config writes,
// tick stimulus, result-side stalls and the verdict; depends on pdpc_pkg,
// pdpc_tick_pkg and pdpc_command_checker
`timescale 1ns / 1ps

module pd_position_current_controller_test;
    import pdpc_pkg::*;
    import pdpc_tick_pkg::*;

    localparam int SETTLE_CYCLES  = 64;     // a bit over one tick of latency
    localparam int HOLD_CYCLES    = 400;    // long result-side hold-off
    localparam int WATCHDOG_LIMIT = 5000;   // cycles with no transaction at all
    localparam int PHASE_TICKS    = 130;
    localparam int PHASES         = 10;

    localparam int          FIELD_MAX = 32'h7fff_ffff;
    localparam int          FIELD_MIN = 32'h8000_0000;
    localparam int unsigned GAIN_MAX  = 31'h7fff_ffff;
    localparam int unsigned Q16_ONE   = 65536;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    t_tick                 tick;
    logic                  out_valid;
    logic                  out_ready;
    logic signed [DATA_W-1:0] current_command;
    logic signed [DATA_W-1:0] angle_radians;
    logic signed [DATA_W-1:0] rate_radians;
    logic                  clamped;

    int mismatch_count;
    int pending;
    int quiet_cycles;
    bit idle_on       = 1'b1;   // random gaps on both sides
    bit hold_off_req  = 1'b0;   // asks the result side for one long stall

    pd_position_current_controller uut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_wr_en           (cfg_wr_en),
        .i_cfg_index           (cfg_index),
        .i_cfg_wdata           (cfg_wdata),
        .i_in_valid            (in_valid),
        .o_in_ready            (in_ready),
        .i_measured_angle      (tick.measured_angle),
        .i_measured_erpm       (tick.measured_erpm),
        .i_target_angle        (tick.target_angle),
        .i_target_rate         (tick.target_rate),
        .i_stiffness_gain      (tick.stiffness_gain),
        .i_damping_gain        (tick.damping_gain),
        .i_feedforward_current (tick.feedforward_current),
        .o_out_valid           (out_valid),
        .i_out_ready           (out_ready),
        .o_current_command     (current_command),
        .o_angle_radians       (angle_radians),
        .o_rate_radians        (rate_radians),
        .o_clamped             (clamped)
    );

    pdpc_command_checker u_command_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_index      (cfg_index),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_tick           (tick),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_result         ({current_command, angle_radians, rate_radians, clamped}),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    // 2 ns clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin : result_side
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        out_ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req && !hold_done) begin
                hold_done    = 1'b1;
                stall_left   = HOLD_CYCLES - 1;
                out_ready   <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog: ends the run if nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // one config register write, only used while the block is idle
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_config(input int unsigned poles, input int unsigned limit,
                                input int unsigned weight);
        write_reg(REG_MOTOR_POLES, CFG_DATA_W'(poles));
        write_reg(REG_CURRENT_LIMIT, CFG_DATA_W'(limit));
        write_reg(REG_FILTER_WEIGHT, CFG_DATA_W'(weight));
    endtask

    // offer one tick transaction, with an optional idle burst ahead of it,
    // and hold it until the block takes it
    task automatic send_tick(input t_tick t);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick     <= t;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic t_tick make_tick(input int angle, input int erpm, input int tgt_angle,
                                        input int tgt_rate, input int unsigned kp,
                                        input int unsigned kd, input int ff);
        t_tick t;
        t.measured_angle      = angle;
        t.measured_erpm       = erpm;
        t.target_angle        = tgt_angle;
        t.target_rate         = tgt_rate;
        t.stiffness_gain      = GAIN_W'(kp);
        t.damping_gain        = GAIN_W'(kd);
        t.feedforward_current = ff;
        return t;
    endfunction

    function automatic int signed_rand(input int unsigned mag);
        int unsigned r;
        r = $urandom_range(0, mag);
        return ($urandom_range(0, 1) == 1) ? -int'(r) : int'(r);
    endfunction

    // mostly plausible control ticks, a quarter full-range noise
    function automatic t_tick random_tick;
        if ($urandom_range(0, 3) == 0) begin
            return make_tick($urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
        end
        return make_tick(signed_rand(3600 * Q16_ONE),    // multiturn degrees
                         signed_rand(20000 * Q16_ONE),   // erpm
                         signed_rand(63 * Q16_ONE),
                         signed_rand(2000 * Q16_ONE),
                         $urandom_range(0, 20 * Q16_ONE),
                         $urandom_range(0, Q16_ONE),
                         signed_rand(10 * Q16_ONE));
    endfunction

    initial begin : stimulus
        int unsigned poles, limit, weight;
        int phase;

        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MOTOR_POLES;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        tick      = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // reset config: zero tick, limit hit exactly and just missed
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 3276800));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, -3276800));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 3276799));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, -3276799));
        // field extremes
        send_tick(make_tick(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX,
                            GAIN_MAX, GAIN_MAX, FIELD_MAX));
        send_tick(make_tick(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN,
                            GAIN_MAX, GAIN_MAX, FIELD_MIN));
        send_tick(make_tick(FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MAX,
                            GAIN_MAX, 0, 0));
        send_tick(make_tick(90 * Q16_ONE, 1000 * Q16_ONE, Q16_ONE, 0,
                            2 * Q16_ONE, Q16_ONE / 2, 0));
        drain();

        // zero limit: command pinned to 0 and flagged
        write_reg(REG_CURRENT_LIMIT, '0);
        send_tick(make_tick(45 * Q16_ONE, 500 * Q16_ONE, 0, 0, Q16_ONE, Q16_ONE, Q16_ONE));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0));
        drain();

        // widest limit, most poles, full filter weight
        write_config(255, GAIN_MAX, 16'hffff);
        send_tick(make_tick(FIELD_MAX, FIELD_MAX, FIELD_MIN, FIELD_MIN,
                            GAIN_MAX, GAIN_MAX, FIELD_MIN));
        send_tick(make_tick(FIELD_MIN, FIELD_MIN, FIELD_MAX, FIELD_MAX,
                            GAIN_MAX, GAIN_MAX, FIELD_MAX));
        send_tick(make_tick(-30 * Q16_ONE, -700 * Q16_ONE, Q16_ONE, -Q16_ONE,
                            Q16_ONE, Q16_ONE, -Q16_ONE));
        drain();

        // zero weight holds the filter, too few poles counts as one pair
        write_config(0, GAIN_MAX, 0);
        send_tick(make_tick(0, FIELD_MAX, 0, 0, 0, Q16_ONE, 0));
        send_tick(make_tick(0, FIELD_MIN, 0, 0, 0, Q16_ONE, 0));
        drain();
        write_config(1, 3276800, 16'hffff);
        send_tick(make_tick(0, FIELD_MIN, 0, 0, 0, Q16_ONE, 0));
        drain();
        write_config(2, 3276800, 6554);
        send_tick(make_tick(0, FIELD_MAX, 0, 0, 0, Q16_ONE, 0));
        drain();

        // random phases, each with its own config
        for (phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 7))
                0:       poles = $urandom_range(0, 1);
                1:       poles = 255;
                2:       poles = 254;
                3:       poles = 2;
                default: poles = $urandom_range(2, 254);
            endcase
            case ($urandom_range(0, 5))
                0:       limit = GAIN_MAX;
                1:       limit = $urandom_range(0, Q16_ONE);
                2:       limit = $urandom & GAIN_MAX;
                default: limit = $urandom_range(Q16_ONE, 100 * Q16_ONE);
            endcase
            case ($urandom_range(0, 5))
                0:       weight = 0;
                1:       weight = 16'hffff;
                default: weight = $urandom_range(0, 16'hffff);
            endcase
            write_config(poles, limit, weight);

            // one long result-side stall while ticks keep coming
            if (phase == 2) begin
                hold_off_req = 1'b1;
            end
            // no idling at all in the closing phases
            if (phase >= PHASES - 2) begin
                idle_on = 1'b0;
            end
            repeat (PHASE_TICKS) send_tick(random_tick());
            drain();
        end

        if (mismatch_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
